/* design/rarst_pkg.sv */
// Package with shared constants, types and sequencer states of the range tree.
`timescale 1ns / 1ps
package rarst_pkg;

  localparam int MaxPos = 1024;
  localparam int AddrW  = 10;
  localparam int IdxW   = 12;
  localparam int PosW   = 11;
  localparam int DataW  = 64;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_M0,
    ST_ADD_M1,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_Q_RD,
    ST_Q_ACC,
    ST_Q_MLO,
    ST_Q_MHI,
    ST_Q_FIN,
    ST_Q_NEXT,
    ST_DONE
  } state_t;

  // Access request to the two index-tree banks.
  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata1;
    logic [DataW-1:0] wdata2;
  } bank_req_t;

endpackage

/* design/rarst_bank.sv */
// Two 1024 x 64 synchronous memories holding the value and weighted index trees.
`timescale 1ns / 1ps
module rarst_bank
  import rarst_pkg::*;
(
  input  logic             clk,
  input  bank_req_t        req,
  output logic [DataW-1:0] rdata1,
  output logic [DataW-1:0] rdata2
);

  logic [DataW-1:0] mem1 [MaxPos];
  logic [DataW-1:0] mem2 [MaxPos];

  // One write port and one registered read port per bank.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem1[req.addr] <= req.wdata1;
      mem2[req.addr] <= req.wdata2;
    end
    if (req.re) begin
      rdata1 <= mem1[req.addr];
      rdata2 <= mem2[req.addr];
    end
  end

endmodule

/* design/range_add_range_sum_tree_core.sv */
// Range add / range sum engine built on two index trees held in memory, one item at a time.
// An add updates n1 and n2 tree nodes at the left end and one past the right end; each
// node costs a read and a write. A query reads m1 and m2 nodes in its two prefixes, and
// its total waits while output is full. After reset, and after each size write, a
// clearing pass zeroes both memories.
`timescale 1ns / 1ps
module range_add_range_sum_tree_core
  import rarst_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [PosW-1:0]         size_in_use,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    opcode,
  input  logic [PosW-1:0]         range_left,
  input  logic [PosW-1:0]         range_right,
  input  logic signed [31:0]      amount,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DataW-1:0] range_total
);

  state_t state, state_next;
  bank_req_t req;
  logic [DataW-1:0] rd1, rd2;

  logic [PosW-1:0]  size_reg;
  logic [AddrW-1:0] clr_cnt;
  logic [PosW-1:0]  lo, hi, i0;
  logic [IdxW-1:0]  idx;
  logic             phase;
  logic [DataW-1:0] amt, d1, d2, s1, s2, preg, total;
  logic [42:0]      plo;
  logic [31:0]      phi;

  logic [PosW-1:0]  n_c, lo_c, hi_c;
  logic             empty_c;
  logic [IdxW-1:0]  lowbit;
  logic             idx_out;
  logic signed [32:0] mul_a;
  logic signed [11:0] mul_b;
  logic signed [44:0] prod;
  logic [DataW-1:0] prod_ext;

  rarst_bank u_bank (
    .clk    (clk),
    .req    (req),
    .rdata1 (rd1),
    .rdata2 (rd2)
  );

  // Clip the incoming range to the positions that exist.
  always_comb begin
    if (size_reg == '0) begin
      n_c = PosW'(1);
    end else if (size_reg > PosW'(MaxPos)) begin
      n_c = PosW'(MaxPos);
    end else begin
      n_c = size_reg;
    end
    lo_c    = (range_left == '0) ? PosW'(1) : range_left;
    hi_c    = (range_right > n_c) ? n_c : range_right;
    empty_c = (range_left > range_right) || (lo_c > hi_c);
  end

  assign lowbit  = idx & (~idx + IdxW'(1));
  assign idx_out = (idx == '0) || (idx > IdxW'(MaxPos));

  // Shared signed 33 x 12 multiplier.
  always_comb begin
    mul_a = {amt[31], amt[31:0]};
    mul_b = {1'b0, lo - PosW'(1)};
    unique case (state)
      ST_ADD_M1: mul_b = {1'b0, hi};
      ST_Q_MLO: begin
        mul_a = {1'b0, s1[31:0]};
        mul_b = {1'b0, i0};
      end
      ST_Q_MHI: begin
        mul_a = {1'b0, s1[63:32]};
        mul_b = {1'b0, i0};
      end
      default: ;
    endcase
    prod     = mul_a * mul_b;
    prod_ext = {{(DataW-45){prod[44]}}, prod};
  end

  assign cfg_ready = (state == ST_IDLE) || (state == ST_CLEAR);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;

  // Next state and memory requests.
  always_comb begin
    state_next = state;
    req.we     = 1'b0;
    req.re     = 1'b0;
    req.addr   = idx[AddrW-1:0];
    req.wdata1 = rd1 + d1;
    req.wdata2 = rd2 + d2;
    unique case (state)
      ST_CLEAR: begin
        req.we     = 1'b1;
        req.addr   = clr_cnt;
        req.wdata1 = '0;
        req.wdata2 = '0;
        if (clr_cnt == AddrW'(MaxPos - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (opcode == OP_QUERY) begin
            state_next = empty_c ? ST_DONE : ST_Q_RD;
          end else if (!empty_c) begin
            state_next = ST_ADD_M0;
          end
        end
      end
      ST_ADD_M0: state_next = ST_UPD_RD;
      ST_ADD_M1: state_next = ST_UPD_RD;
      ST_UPD_RD: begin
        if (idx_out) begin
          state_next = phase ? ST_IDLE : ST_ADD_M1;
        end else begin
          req.re     = 1'b1;
          state_next = ST_UPD_WR;
        end
      end
      ST_UPD_WR: begin
        req.we     = 1'b1;
        state_next = ST_UPD_RD;
      end
      ST_Q_RD: begin
        if (idx == '0) begin
          state_next = ST_Q_MLO;
        end else begin
          req.re     = 1'b1;
          state_next = ST_Q_ACC;
        end
      end
      ST_Q_ACC:  state_next = ST_Q_RD;
      ST_Q_MLO:  state_next = ST_Q_MHI;
      ST_Q_MHI:  state_next = ST_Q_FIN;
      ST_Q_FIN:  state_next = ST_Q_NEXT;
      ST_Q_NEXT: state_next = phase ? ST_DONE : ST_Q_RD;
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (cfg_valid && cfg_ready) state_next = ST_CLEAR;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      size_reg  <= PosW'(MaxPos);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        size_reg <= size_in_use;
        clr_cnt  <= '0;
      end else if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AddrW'(1);
      end
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        lo    <= lo_c;
        hi    <= hi_c;
        amt   <= {{(DataW-32){amount[31]}}, amount};
        idx   <= {1'b0, hi_c};
        i0    <= hi_c;
        s1    <= '0;
        s2    <= '0;
        phase <= 1'b0;
        total <= '0;
      end
      ST_ADD_M0: begin
        d1    <= amt;
        d2    <= prod_ext;
        idx   <= {1'b0, lo};
        phase <= 1'b0;
      end
      ST_ADD_M1: begin
        d1    <= -amt;
        d2    <= -prod_ext;
        idx   <= {1'b0, hi} + IdxW'(1);
        phase <= 1'b1;
      end
      ST_UPD_WR: idx <= idx + lowbit;
      ST_Q_ACC: begin
        s1  <= s1 + rd1;
        s2  <= s2 + rd2;
        idx <= idx - lowbit;
      end
      ST_Q_MLO: plo <= prod[42:0];
      ST_Q_MHI: phi <= prod[31:0];
      ST_Q_FIN: preg <= {phi, 32'b0} + {{(DataW-43){1'b0}}, plo} - s2;
      ST_Q_NEXT: begin
        if (phase) begin
          total <= total - preg;
        end else begin
          total <= preg;
          idx   <= {1'b0, lo - PosW'(1)};
          i0    <= lo - PosW'(1);
          s1    <= '0;
          s2    <= '0;
          phase <= 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) range_total <= total;
      end
      default: ;
    endcase
  end

endmodule

/* tb/range_add_range_sum_tree_core_tb.sv */
// Testbench for the range add / range sum tree core, checked against a flat array model.
`timescale 1ns / 1ps
module range_add_range_sum_tree_core_tb;
  import rarst_pkg::*;

  // Flat-array model of the tree and the queue of sums still owed by the block.
  class range_sum_board;
    logic [DataW-1:0] pos_value [1:MaxPos];
    int unsigned      span;
    logic [DataW-1:0] pending_totals [$];
    int unsigned      errors;

    function new();
      errors = 0;
      resize(11'd1024);
    endfunction

    // A size write clears every position; out-of-range sizes are clamped.
    function void resize(logic [PosW-1:0] sz);
      span = (sz == 0) ? 1 : ((sz > MaxPos) ? MaxPos : sz);
      for (int i = 1; i <= MaxPos; i++) pos_value[i] = '0;
    endfunction

    // Applies an accepted add, or works out the total that a query owes.
    function void note_input(logic op, logic [PosW-1:0] lft, logic [PosW-1:0] rgt,
                             logic signed [31:0] amt);
      int unsigned      lo;
      int unsigned      hi;
      logic [DataW-1:0] acc;
      logic [DataW-1:0] ext;
      lo  = (lft < 1) ? 1 : lft;
      hi  = (rgt > span) ? span : rgt;
      ext = {{32{amt[31]}}, amt};
      acc = '0;
      if (lft <= rgt) begin
        for (int i = lo; i <= hi; i++) begin
          if (op == OP_ADD) pos_value[i] += ext;
          else acc += pos_value[i];
        end
      end
      if (op == OP_QUERY) pending_totals.push_back(acc);
    endfunction

    // Compares one transferred total with the oldest owed one.
    function void check_result(logic [DataW-1:0] got);
      logic [DataW-1:0] want;
      if (pending_totals.size() == 0) begin
        $error("range_total: unexpected result, actual %h", got);
        errors++;
        return;
      end
      want = pending_totals.pop_front();
      if (got !== want) begin
        $error("range_total: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [PosW-1:0]         size_in_use;
  logic                    in_valid;
  logic                    in_ready;
  logic                    opcode;
  logic [PosW-1:0]         range_left;
  logic [PosW-1:0]         range_right;
  logic signed [31:0]      amount;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [DataW-1:0] range_total;

  range_sum_board board;
  int unsigned    cycle_count;
  int unsigned    stall_mode;

  range_add_range_sum_tree_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .size_in_use(size_in_use),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .range_left(range_left), .range_right(range_right), .amount(amount),
    .out_valid(out_valid), .out_ready(out_ready), .range_total(range_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Short gaps most of the time, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output side: random stalls, with stretches of none; results checked as they transfer.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 2);
    if (!rst && out_valid && out_ready) board.check_result(range_total);
    if (stall_mode == 0) out_ready <= 1'b1;
    else if (stall_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 9) < 3);
    if (cycle_count > 600000) begin
      $display("[range_add_range_sum_tree_core] ERROR");
      $finish;
    end
  end

  // Stops sending, waits until every owed total has transferred, then lets an add drain.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_totals.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_size(logic [PosW-1:0] sz);
    wait_drained();
    cfg_valid   <= 1'b1;
    size_in_use <= sz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.resize(sz);
    cfg_valid <= 1'b0;
  endtask

  // Sends one item and holds it until the transfer.
  task automatic send_item(logic op, logic [PosW-1:0] lft, logic [PosW-1:0] rgt,
                           logic signed [31:0] amt);
    int unsigned gap;
    in_valid    <= 1'b1;
    opcode      <= op;
    range_left  <= lft;
    range_right <= rgt;
    amount      <= amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(op, lft, rgt, amt);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed ranges inside the tree, the rest raw 11-bit values.
  task automatic run_random(int unsigned count);
    int unsigned     span;
    logic [PosW-1:0] a;
    logic [PosW-1:0] b;
    logic [PosW-1:0] t;
    span = board.span;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        a = PosW'($urandom_range(1, span));
        b = PosW'($urandom_range(1, span));
        if (a > b) begin
          t = a; a = b; b = t;
        end
      end else begin
        a = PosW'($urandom);
        b = PosW'($urandom);
      end
      send_item($urandom_range(0, 9) < 4 ? OP_QUERY : OP_ADD, a, b, pick_amount());
    end
  endtask

  initial begin
    board       = new();
    cycle_count = 0;
    stall_mode  = 0;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    size_in_use = 11'd1024;
    in_valid    = 1'b0;
    opcode      = OP_ADD;
    range_left  = '0;
    range_right = '0;
    amount      = '0;
    out_ready   = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, empty and clipped ranges, wrapping sums.
    send_item(OP_QUERY, 11'd1, 11'd1024, 0);
    send_item(OP_ADD, 11'd1, 11'd1024, 32'sh7FFFFFFF);
    send_item(OP_ADD, 11'd0, 11'd2047, 32'sh7FFFFFFF);
    send_item(OP_QUERY, 11'd0, 11'd2047, 0);
    send_item(OP_ADD, 11'd512, 11'd512, 32'sh80000000);
    send_item(OP_QUERY, 11'd512, 11'd512, 32'sh12345678);
    send_item(OP_ADD, 11'd10, 11'd5, 32'sd99);
    send_item(OP_QUERY, 11'd10, 11'd5, 0);
    send_item(OP_ADD, 11'd1025, 11'd2047, 32'sd7);
    send_item(OP_QUERY, 11'd1025, 11'd2047, 0);
    send_item(OP_QUERY, 11'd1024, 11'd1024, 0);
    send_item(OP_ADD, 11'd1, 11'd1, -32'sd1);
    send_item(OP_QUERY, 11'd1, 11'd2, 0);
    send_item(OP_QUERY, 11'd2047, 11'd0, 0);

    // Sender holds off until every owed total is back.
    wait_drained();
    run_random(60);

    write_size(11'd1);
    send_item(OP_ADD, 11'd0, 11'd1, 32'sh80000000);
    send_item(OP_QUERY, 11'd1, 11'd2047, 0);
    send_item(OP_QUERY, 11'd2, 11'd3, 0);
    run_random(30);

    write_size(11'd0);
    run_random(30);

    write_size(11'd2047);
    run_random(60);

    write_size(11'd2);
    run_random(50);

    write_size(11'd7);
    run_random(70);

    write_size(11'd1000);
    run_random(80);

    write_size(PosW'($urandom_range(3, 1024)));
    run_random(80);

    write_size(11'd1024);
    run_random(40);

    in_valid <= 1'b0;
    while (board.pending_totals.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending_totals.size() == 0) begin
      $display("[range_add_range_sum_tree_core] OK");
    end else begin
      $display("[range_add_range_sum_tree_core] ERROR");
    end
    $finish;
  end

endmodule
